[hdl/pce_pkg.sv]
// Shared types, constants and codes of the PMT pulse charge extractor.
// Used by the front and back parts and the top level.
`default_nettype none
package pce_pkg;

   localparam int MAX_SAMPLES = 1024;
   localparam int SAMPLE_BITS = 10;
   localparam int ADDR_BITS   = $clog2(MAX_SAMPLES);
   localparam int COUNT_BITS  = ADDR_BITS + 1;
   localparam int BSUM_BITS   = 20;
   localparam int CHARGE_BITS = 29;

   // configuration register indexes
   localparam logic [2:0] REG_BASELINE_LEN   = 3'd0;
   localparam logic [2:0] REG_TRIGGER_POS    = 3'd1;
   localparam logic [2:0] REG_TRIGGER_TOL    = 3'd2;
   localparam logic [2:0] REG_START_FRACTION = 3'd3;
   localparam logic [2:0] REG_END_FRACTION   = 3'd4;
   localparam logic [2:0] REG_CHARGE_GAIN    = 3'd5;
   localparam logic [2:0] REG_MIN_CHARGE     = 3'd6;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_WINDOW   = 2'd1;
   localparam logic [1:0] STATUS_LOW_CHRG = 2'd2;

   typedef struct packed {
      logic [9:0]              baseline_len;
      logic [9:0]              trigger_pos;
      logic [9:0]              trigger_tol;
      logic [7:0]              start_fraction;
      logic [7:0]              end_fraction;
      logic [15:0]             charge_gain;
      logic [CHARGE_BITS-1:0]  min_charge;
   } cfg_type;

   // summary of one stored waveform, handed from front to back
   typedef struct packed {
      logic                    channel;
      logic [COUNT_BITS-1:0]   count;
      logic [SAMPLE_BITS-1:0]  min_value;
      logic [ADDR_BITS-1:0]    min_pos;
      logic [BSUM_BITS-1:0]    bsum;
   } desc_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_A_RD,
      ST_A_EV,
      ST_B_RD,
      ST_B_EV,
      ST_CHG,
      ST_FIN,
      ST_OUT
   } back_state_type;

endpackage
`default_nettype wire

[hdl/pce_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module pce_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[hdl/pce_front.sv]
// Front part: accepts samples, stores them, tracks minimum, baseline sum and
// count, and hands a waveform summary to the back through a one-entry queue.
`default_nettype none
module pce_front
   import pce_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [SAMPLE_BITS-1:0] sample,
   input  wire logic                   channel,
   input  wire logic                   last_sample,
   input  wire logic [9:0]             baseline_len,
   output logic                        wr_en,
   output logic      [ADDR_BITS-1:0]   wr_addr,
   output logic      [SAMPLE_BITS-1:0] wr_data,
   output logic                        q_valid,
   output desc_type                    q_desc,
   input  wire logic                   q_release
);

   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [ADDR_BITS-1:0]   minpos_ff, minpos_in;
   logic [BSUM_BITS-1:0]   bsum_ff, bsum_in;
   logic                   chan_ff, chan_in;
   logic                   qv_ff, qv_in;
   desc_type               qd_ff, qd_in;
   logic                   accept;
   logic                   room;

   assign req_tready = !qv_ff;
   assign accept     = req_tvalid && req_tready;
   assign room       = count_ff < COUNT_BITS'(MAX_SAMPLES);

   assign wr_en   = accept && room;
   assign wr_addr = count_ff[ADDR_BITS-1:0];
   assign wr_data = sample;
   assign q_valid = qv_ff;
   assign q_desc  = qd_ff;

   // update waveform statistics
   always_comb begin
      count_in  = count_ff;
      min_in    = min_ff;
      minpos_in = minpos_ff;
      bsum_in   = bsum_ff;
      chan_in   = chan_ff;
      qv_in     = qv_ff && !q_release;
      qd_in     = qd_ff;
      if (accept) begin
         if (room) begin
            if (count_ff == '0) begin
               chan_in = channel;
            end
            if (sample < min_ff || count_ff == '0) begin
               min_in    = sample;
               minpos_in = count_ff[ADDR_BITS-1:0];
            end
            if (count_ff < {1'b0, baseline_len}) begin
               bsum_in = bsum_ff + BSUM_BITS'(sample);
            end
            count_in = count_ff + 1'b1;
         end
         if (last_sample) begin
            // push summary, restart waveform
            qd_in.channel   = chan_in;
            qd_in.count     = count_in;
            qd_in.min_value = min_in;
            qd_in.min_pos   = minpos_in;
            qd_in.bsum      = bsum_in;
            qv_in           = 1'b1;
            count_in        = '0;
            min_in          = '1;
            minpos_in       = '0;
            bsum_in         = '0;
            chan_in         = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         min_ff    <= '1;
         minpos_ff <= '0;
         bsum_ff   <= '0;
         chan_ff   <= 1'b0;
         qv_ff     <= 1'b0;
      end else begin
         count_ff  <= count_in;
         min_ff    <= min_in;
         minpos_ff <= minpos_in;
         bsum_ff   <= bsum_in;
         chan_ff   <= chan_in;
         qv_ff     <= qv_in;
      end
      qd_ff <= qd_in;
   end

endmodule
`default_nettype wire

[hdl/pce_back.sv]
// Back part: divides out the baseline, scans the stored samples for the
// threshold crossings, integrates, scales the charge and holds the result.
`default_nettype none
module pce_back
   import pce_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  cfg_type                     cfg,
   input  wire logic                   q_valid,
   input  desc_type                    q_desc,
   output logic                        q_release,
   output logic      [ADDR_BITS-1:0]   rd_addr,
   input  wire logic [SAMPLE_BITS-1:0] rd_data,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [79:0]            rsp_tdata,
   output logic                        rsp_tuser
);

   back_state_type st_ff, st_in;
   desc_type       d_ff, d_in;
   logic [28:0]    num_ff, num_in;
   logic [9:0]     rem_ff, rem_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic [9:0]     len_ff, len_in;
   logic signed [28:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [ADDR_BITS-1:0] idx_ff, idx_in;
   logic signed [29:0] sum_ff, sum_in;
   logic signed [47:0] prod_ff, prod_in;
   logic [1:0]     o_status_ff, o_status_in;
   logic [28:0]    o_charge_ff, o_charge_in;
   logic [17:0]    base;
   logic [10:0]    rem_t;
   logic           ge;
   logic signed [19:0] term, dpeak;
   logic signed [28:0] term256;
   logic signed [30:0] neg_sum;
   logic signed [47:0] adj;
   logic signed [31:0] quo;
   logic signed [11:0] win_lo;
   logic [10:0]    win_hi;
   logic [COUNT_BITS-1:0] idx_next;
   logic [9:0]     len_pick;

   assign base     = num_ff[17:0];
   assign rem_t    = {rem_ff, num_ff[28]};
   assign ge       = rem_t >= {1'b0, len_ff};
   assign term     = $signed({2'b00, rd_data, 8'h00}) - $signed({2'b00, base});
   assign dpeak    = $signed({2'b00, d_ff.min_value, 8'h00}) - $signed({2'b00, base});
   assign term256  = 29'(term) <<< 8;
   assign neg_sum  = -31'(sum_ff);
   assign adj      = prod_ff[47] ? prod_ff + 48'sd65535 : prod_ff;
   assign quo      = 32'(adj >>> 16);
   assign win_hi   = {1'b0, cfg.trigger_pos} + {1'b0, cfg.trigger_tol};
   assign win_lo   = $signed({2'b00, cfg.trigger_pos}) - $signed({2'b00, cfg.trigger_tol});
   assign idx_next = {1'b0, idx_ff} + 1'b1;
   assign rd_addr  = idx_ff;

   // pick baseline length, clamped to the stored count and to at least one
   always_comb begin
      if (q_desc.count < {1'b0, cfg.baseline_len}) begin
         len_pick = q_desc.count[9:0];
      end else begin
         len_pick = cfg.baseline_len;
      end
      if (len_pick == '0) begin
         len_pick = 10'd1;
      end
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (q_valid) st_in = ST_DIV;
         ST_DIV:  if (cnt_ff == 5'd28) st_in = ST_MUL;
         ST_MUL: begin
            if (cfg.baseline_len < d_ff.min_pos) st_in = ST_A_RD;
            else st_in = ST_B_RD;
         end
         ST_A_RD: st_in = ST_A_EV;
         ST_A_EV: begin
            if (term256 < lo_ff || idx_next >= {1'b0, d_ff.min_pos}) st_in = ST_B_RD;
            else st_in = ST_A_RD;
         end
         ST_B_RD: st_in = ST_B_EV;
         ST_B_EV: begin
            if ((idx_ff >= d_ff.min_pos && term256 > hi_ff) || idx_next >= d_ff.count)
               st_in = ST_CHG;
            else st_in = ST_B_RD;
         end
         ST_CHG:  st_in = ST_FIN;
         ST_FIN:  st_in = ST_OUT;
         ST_OUT:  if (rsp_tready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      d_in        = d_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      len_in      = len_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      idx_in      = idx_ff;
      sum_in      = sum_ff;
      prod_in     = prod_ff;
      o_status_in = o_status_ff;
      o_charge_in = o_charge_ff;
      q_release   = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            d_in   = q_desc;
            len_in = len_pick;
            num_in = {1'b0, q_desc.bsum, 8'h00} + 29'(len_pick >> 1);
            rem_in = '0;
            cnt_in = '0;
         end
         ST_DIV: begin
            // one restoring quotient bit per cycle
            rem_in = ge ? 10'(rem_t - {1'b0, len_ff}) : rem_t[9:0];
            num_in = {num_ff[27:0], ge};
            cnt_in = cnt_ff + 1'b1;
         end
         ST_MUL: begin
            lo_in  = 29'(dpeak) * 29'($signed({1'b0, cfg.start_fraction}));
            hi_in  = 29'(dpeak) * 29'($signed({1'b0, cfg.end_fraction}));
            sum_in = '0;
            if (cfg.baseline_len < d_ff.min_pos) idx_in = cfg.baseline_len;
            else idx_in = d_ff.min_pos;
         end
         ST_A_EV: begin
            // start crossing found or none before the peak
            if (term256 < lo_ff) idx_in = idx_ff;
            else if (idx_next >= {1'b0, d_ff.min_pos}) idx_in = d_ff.min_pos;
            else idx_in = idx_next[ADDR_BITS-1:0];
         end
         ST_B_EV: begin
            if (idx_ff >= d_ff.min_pos && term256 > hi_ff) begin
               q_release = 1'b1;
            end else begin
               sum_in = sum_ff + 30'(term);
               if (idx_next >= d_ff.count) q_release = 1'b1;
               else idx_in = idx_next[ADDR_BITS-1:0];
            end
         end
         ST_CHG: begin
            prod_in = 48'(neg_sum) * 48'($signed({1'b0, cfg.charge_gain}));
         end
         ST_FIN: begin
            // saturate and classify
            if (quo > 32'sd268435455) o_charge_in = 29'h0FFFFFFF;
            else if (quo < -32'sd268435456) o_charge_in = 29'h10000000;
            else o_charge_in = quo[28:0];
            if ({1'b0, d_ff.min_pos} > win_hi
                || $signed({2'b00, d_ff.min_pos}) < win_lo) begin
               o_status_in = STATUS_WINDOW;
            end else if ($signed(o_charge_in) < $signed(cfg.min_charge)) begin
               o_status_in = STATUS_LOW_CHRG;
            end else begin
               o_status_in = STATUS_OK;
            end
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      rsp_tvalid = (st_ff == ST_OUT);
      rsp_tuser  = d_ff.channel;
      rsp_tdata  = {3'b000, o_charge_ff,
                    18'(base - {d_ff.min_value, 8'h00}),
                    base, d_ff.min_pos, o_status_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
      d_ff        <= d_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      len_ff      <= len_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      prod_ff     <= prod_in;
      o_status_ff <= o_status_in;
      o_charge_ff <= o_charge_in;
   end

endmodule
`default_nettype wire

[hdl/pmt_pulse_charge_extractor.sv]
// Top level of the PMT pulse charge extractor: configuration registers,
// sample RAM, front and back parts. Depends on pce_pkg, pce_ram, pce_front, pce_back.
//
// Samples are taken one per cycle while the front is free; a sample with
// tlast closes the waveform and one result follows. After the last sample
// the back runs the baseline division (one quotient bit a cycle), then
// scans the stored samples on the single RAM read port, with a read state
// and an evaluate state per sample: one pass from baseline_len to the start
// crossing, one from the start to the end crossing. From the last sample
// to the end of the scan the input stalls; once the scan ends, the next
// waveform is accepted while the result waits in the output register.
`default_nettype none
module pmt_pulse_charge_extractor
   import pce_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [9:0] sample
   input  wire logic        req_tuser,  // [0] channel
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [79:0] rsp_tdata,  // status, peak_index, baseline_level,
                                        // amplitude, charge
   output logic             rsp_tuser,  // [0] out_channel
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [28:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     wr_en;
   logic [ADDR_BITS-1:0]   wr_addr, rd_addr;
   logic [SAMPLE_BITS-1:0] wr_data, rd_data;
   logic     q_valid, q_release;
   desc_type q_desc;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            REG_BASELINE_LEN:   cfg_in.baseline_len   = csr_wdata[9:0];
            REG_TRIGGER_POS:    cfg_in.trigger_pos    = csr_wdata[9:0];
            REG_TRIGGER_TOL:    cfg_in.trigger_tol    = csr_wdata[9:0];
            REG_START_FRACTION: cfg_in.start_fraction = csr_wdata[7:0];
            REG_END_FRACTION:   cfg_in.end_fraction   = csr_wdata[7:0];
            REG_CHARGE_GAIN:    cfg_in.charge_gain    = csr_wdata[15:0];
            REG_MIN_CHARGE:     cfg_in.min_charge     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.baseline_len   <= 10'd64;
         cfg_ff.trigger_pos    <= 10'd512;
         cfg_ff.trigger_tol    <= 10'd16;
         cfg_ff.start_fraction <= 8'd25;
         cfg_ff.end_fraction   <= 8'd25;
         cfg_ff.charge_gain    <= 16'd1311;
         cfg_ff.min_charge     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pce_ram #(.DEPTH(MAX_SAMPLES), .WIDTH(SAMPLE_BITS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pce_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .sample       (req_tdata[SAMPLE_BITS-1:0]),
      .channel      (req_tuser),
      .last_sample  (req_tlast),
      .baseline_len (cfg_ff.baseline_len),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .q_valid      (q_valid),
      .q_desc       (q_desc),
      .q_release    (q_release)
   );

   pce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_desc     (q_desc),
      .q_release  (q_release),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
